>>> hdl/cfvc_pkg.sv
// ----------------------------------------------------------------------------
// cfvc_pkg
// Shared types, constants and helper functions of the circle-follow
// velocity controller.
// ----------------------------------------------------------------------------
package cfvc_pkg;

  localparam int unsigned CfgW      = 15;
  localparam int unsigned CfgIdxW   = 2;

  // input item kinds
  localparam logic CMD_GOAL = 1'b0;
  localparam logic CMD_ODOM = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LIN_SPEED = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_SPEED = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOWDOWN  = 2'd2;

  localparam logic [CfgW-1:0] LIN_SPEED_RST = 15'd819;
  localparam logic [CfgW-1:0] ROT_SPEED_RST = 15'd819;
  localparam logic [CfgW-1:0] SLOWDOWN_RST  = 15'd8192;
  localparam logic [CfgW-1:0] SLOWDOWN_MIN  = 15'd4096;

  // hysteresis modes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;

  // tangent direction latch
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

  localparam logic [31:0] DIST_LO = 32'd19661;
  localparam logic [31:0] DIST_HI = 32'd65536;
  localparam logic [31:0] ANG_LO  = 32'd410;
  localparam logic [31:0] ANG_HI  = 32'd819;

  localparam logic signed [31:0] LIM31    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  localparam int unsigned SqrtIter   = 32;
  localparam int unsigned DivIter    = 31;
  localparam int unsigned CordicIter = 16;

  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] a;
    begin
      unique case (i)
        4'd0:  a = 17'd51472;
        4'd1:  a = 17'd30386;
        4'd2:  a = 17'd16055;
        4'd3:  a = 17'd8150;
        4'd4:  a = 17'd4091;
        4'd5:  a = 17'd2047;
        4'd6:  a = 17'd1024;
        4'd7:  a = 17'd512;
        4'd8:  a = 17'd256;
        4'd9:  a = 17'd128;
        4'd10: a = 17'd64;
        4'd11: a = 17'd32;
        4'd12: a = 17'd16;
        4'd13: a = 17'd8;
        4'd14: a = 17'd4;
        4'd15: a = 17'd2;
      endcase
      return a;
    end
  endfunction

  function automatic logic [1:0] hyst(input logic [1:0] st, input logic [31:0] e,
                                      input logic [31:0] lo, input logic [31:0] hi);
    logic [1:0] nx;
    begin
      unique case (st)
        MODE_STOP: begin
          if (e > hi) nx = MODE_FULL;
          else if (e >= lo) nx = MODE_SLOW;
          else nx = MODE_STOP;
        end
        MODE_FULL: begin
          if (e <= lo) nx = MODE_STOP;
          else if (e <= hi) nx = MODE_SLOW;
          else nx = MODE_FULL;
        end
        default: begin
          if (e >= hi) nx = MODE_FULL;
          else if (e <= lo) nx = MODE_STOP;
          else nx = MODE_SLOW;
        end
      endcase
      return nx;
    end
  endfunction

  function automatic logic signed [31:0] clamp31(input logic signed [35:0] v);
    logic signed [31:0] r;
    begin
      if (v > 36'(LIM31)) r = LIM31;
      else if (v < -36'(LIM31)) r = -LIM31;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    begin
      if (v > 36'sd32767) r = 16'sh7FFF;
      else if (v < -36'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
    end
  endfunction

  function automatic logic signed [17:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] r;
    begin
      if (a > PI_Q13) r = a - TWO_PI_Q13;
      else if (a < -PI_Q13) r = a + TWO_PI_Q13;
      else r = a;
      return r;
    end
  endfunction

endpackage

>>> hdl/cfvc_sqrt.sv
// ----------------------------------------------------------------------------
// cfvc_sqrt
// Iterative floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module cfvc_sqrt import cfvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] op_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [63:0] src_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem_q, src_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(SqrtIter - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      src_q  <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      src_q <= {src_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 34'(rem_sh - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

>>> hdl/cfvc_div.sv
// ----------------------------------------------------------------------------
// cfvc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in 31 bits (top half of the numerator below the divisor).
// ----------------------------------------------------------------------------
module cfvc_div import cfvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [30:0] quo_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [30:0] low_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [30:0] quo_q;
  logic [32:0] rem_sh;

  assign rem_sh = {rem_q, low_q[30]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(DivIter - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[61:31]};
      low_q <= num_i[30:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      low_q <= {low_q[29:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= 32'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[29:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[29:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

>>> hdl/cfvc_cordic.sv
// ----------------------------------------------------------------------------
// cfvc_cordic
// Iterative rotation-mode CORDIC giving cosine and sine in Q.30 from a
// Q2.13 angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module cfvc_cordic import cfvc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] ang_i,
  output logic               busy_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic               busy_q;
  logic [3:0]         cnt_q;
  logic signed [33:0] x_q, y_q;
  logic signed [19:0] z_q;
  logic               neg_q;
  logic signed [17:0] ang_ext, ang_red;
  logic               ang_neg;
  logic signed [33:0] dx, dy, x_out, y_out;
  logic signed [19:0] dz;

  // fold into the right half plane, flip the result back at the end
  always_comb begin
    ang_ext = 18'(ang_i);
    ang_neg = 1'b0;
    ang_red = ang_ext;
    if (ang_ext > HALF_PI_Q13) begin
      ang_red = ang_ext - PI_Q13;
      ang_neg = 1'b1;
    end else if (ang_ext < -HALF_PI_Q13) begin
      ang_red = ang_ext + PI_Q13;
      ang_neg = 1'b1;
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign dz = $signed({3'b000, atan_q16(cnt_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'(CordicIter - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CORDIC_K;
      y_q   <= '0;
      z_q   <= {ang_red[16:0], 3'b000};
      neg_q <= ang_neg;
    end else if (busy_q) begin
      if (!z_q[19]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - dz;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + dz;
      end
    end
  end

  assign x_out  = neg_q ? -x_q : x_q;
  assign y_out  = neg_q ? -y_q : y_q;
  assign cos_o  = x_out[31:0];
  assign sin_o  = y_out[31:0];
  assign busy_o = busy_q;

endmodule

>>> hdl/circle_follow_velocity_controller.sv
// ----------------------------------------------------------------------------
// circle_follow_velocity_controller
// Circle-following velocity controller: goal and odometry beats in, one
// body-frame velocity command per odometry beat out.
// ----------------------------------------------------------------------------
// A goal beat gives no result. An odometry beat goes through a small
// sequencer that drives one 32x32 multiplier, a square root unit (used
// for four vector lengths) and a divider (used for up to six quotients),
// with a 16-step CORDIC overlapping the last two divisions. in_ready_o is
// high only while the sequencer is idle. A finished result sits in the
// output register, and the next beat can be taken meanwhile.
module circle_follow_velocity_controller import cfvc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [15:0]  heading_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  vel_x_o,
  output logic signed [15:0]  vel_y_o,
  output logic signed [15:0]  ang_vel_o,
  output logic [1:0]          lin_mode_o,
  output logic [1:0]          rot_mode_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_NA    = 5'd1;
  localparam logic [4:0] ST_NB    = 5'd2;
  localparam logic [4:0] ST_NC    = 5'd3;
  localparam logic [4:0] ST_NW    = 5'd4;
  localparam logic [4:0] ST_DGO   = 5'd5;
  localparam logic [4:0] ST_DW    = 5'd6;
  localparam logic [4:0] ST_LATCH = 5'd7;
  localparam logic [4:0] ST_M0    = 5'd8;
  localparam logic [4:0] ST_M1    = 5'd9;
  localparam logic [4:0] ST_M2    = 5'd10;
  localparam logic [4:0] ST_MODES = 5'd11;
  localparam logic [4:0] ST_CW    = 5'd12;
  localparam logic [4:0] ST_P0    = 5'd13;
  localparam logic [4:0] ST_P1    = 5'd14;
  localparam logic [4:0] ST_P2    = 5'd15;
  localparam logic [4:0] ST_P3    = 5'd16;
  localparam logic [4:0] ST_P4    = 5'd17;
  localparam logic [4:0] ST_P5    = 5'd18;
  localparam logic [4:0] ST_P6    = 5'd19;
  localparam logic [4:0] ST_P7    = 5'd20;
  localparam logic [4:0] ST_P8    = 5'd21;
  localparam logic [4:0] ST_OUT   = 5'd22;

  // which vector length is being formed
  localparam logic [1:0] NS_R   = 2'd0;
  localparam logic [1:0] NS_RAD = 2'd1;
  localparam logic [1:0] NS_D   = 2'd2;
  localparam logic [1:0] NS_DE  = 2'd3;

  // which quotient is being formed
  localparam logic [2:0] DS_UX = 3'd0;
  localparam logic [2:0] DS_UY = 3'd1;
  localparam logic [2:0] DS_NX = 3'd2;
  localparam logic [2:0] DS_NY = 3'd3;
  localparam logic [2:0] DS_GS = 3'd4;
  localparam logic [2:0] DS_WS = 3'd5;

  logic [4:0] state_q, state_d;
  logic [1:0] nsel_q, nsel_d;
  logic [2:0] dsel_q, dsel_d;
  logic [1:0] dir_q, dir_d;
  logic [1:0] lin_q, lin_d, rot_q, rot_d;
  logic       out_valid_q, out_valid_d;
  logic [CfgW-1:0] lin_spd_q, rot_spd_q, slow_q;

  logic signed [31:0] px_q, py_q, gx_q, gy_q;
  logic signed [15:0] hd_q, gyaw_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic [31:0]        r_q, rad_q, d_q, de_q;
  logic signed [31:0] ux_q, uy_q, nx_q, ny_q, e_q, vlx_q, vly_q;
  logic signed [31:0] t1_q, t2_q, t3_q, t4_q;
  logic [CfgW-1:0]    gslow_q, wslow_q;
  logic signed [17:0] tx_q, ty_q, od_q;
  logic signed [15:0] vx_q, vy_q;
  logic signed [15:0] vel_x_q, vel_y_q, ang_vel_q;
  logic [1:0]         lin_mode_q, rot_mode_q;

  logic               in_fire, out_load;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] na, nb, dxc, dyc;
  logic               sq_start, sq_busy;
  logic [31:0]        sq_root;
  logic [63:0]        sq_op;
  logic               div_start, div_busy, div_signed, div_neg;
  logic signed [31:0] div_sa;
  logic [31:0]        div_mag, div_den;
  logic [CfgW-1:0]    div_spd, vs;
  logic [61:0]        div_num;
  logic [30:0]        div_quo;
  logic signed [31:0] div_res, quo_s;
  logic               cor_start, cor_busy;
  logic signed [31:0] cos_v, sin_v;
  logic signed [17:0] hn, gyw, od;
  logic [17:0]        od_mag;
  logic [1:0]         dir_new;
  logic signed [17:0] uxs, uys;
  logic signed [33:0] ediff;
  logic signed [31:0] gc, vspd;
  logic signed [15:0] w_mag;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign vs   = (slow_q < SLOWDOWN_MIN) ? SLOWDOWN_MIN : slow_q;
  assign vspd = $signed({17'd0, lin_spd_q});
  assign gc   = (lin_q == MODE_FULL) ? vspd : $signed({17'd0, gslow_q});

  // length operands
  assign dxc = clamp31(36'(px_q) - 36'(gx_q));
  assign dyc = clamp31(36'(py_q) - 36'(gy_q));

  always_comb begin
    unique case (nsel_q)
      NS_R:    begin na = px_q;  nb = py_q;  end
      NS_RAD:  begin na = gx_q;  nb = gy_q;  end
      NS_D:    begin na = vlx_q; nb = vly_q; end
      default: begin na = dxc;   nb = dyc;   end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_NA:   begin mul_a = na;   mul_b = na;    end
      ST_NB:   begin mul_a = nb;   mul_b = nb;    end
      ST_M0:   begin mul_a = e_q;  mul_b = ux_q;  end
      ST_M1:   begin mul_a = e_q;  mul_b = uy_q;  end
      ST_P0:   begin mul_a = nx_q; mul_b = cos_v; end
      ST_P1:   begin mul_a = ny_q; mul_b = sin_v; end
      ST_P2:   begin mul_a = ny_q; mul_b = cos_v; end
      ST_P3:   begin mul_a = nx_q; mul_b = sin_v; end
      ST_P4:   begin mul_a = t1_q; mul_b = gc;    end
      ST_P5:   begin mul_a = t2_q; mul_b = vspd;  end
      ST_P6:   begin mul_a = t3_q; mul_b = gc;    end
      ST_P7:   begin mul_a = t4_q; mul_b = vspd;  end
      default: begin mul_a = '0;   mul_b = '0;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign sq_start = (state_q == ST_NC);
  assign sq_op    = $unsigned(acc_q + prod_q);

  cfvc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  // divider operands: signed lengths scaled by 2^30, or speed scaled by 2^12
  always_comb begin
    div_sa     = '0;
    div_den    = '0;
    div_signed = 1'b1;
    div_spd    = '0;
    unique case (dsel_q)
      DS_UX:   begin div_sa = px_q;  div_den = r_q; end
      DS_UY:   begin div_sa = py_q;  div_den = r_q; end
      DS_NX:   begin div_sa = vlx_q; div_den = d_q; end
      DS_NY:   begin div_sa = vly_q; div_den = d_q; end
      DS_GS:   begin div_signed = 1'b0; div_spd = lin_spd_q; div_den = {17'd0, vs}; end
      default: begin div_signed = 1'b0; div_spd = rot_spd_q; div_den = {17'd0, vs}; end
    endcase
  end

  assign div_neg   = div_signed && div_sa[31];
  assign div_mag   = div_sa[31] ? $unsigned(-div_sa) : $unsigned(div_sa);
  assign div_num   = div_signed ? {div_mag, 30'd0} : {35'd0, div_spd, 12'd0};
  assign div_start = (state_q == ST_DGO);
  assign quo_s     = $signed({1'b0, div_quo});
  assign div_res   = div_neg ? -quo_s : quo_s;

  cfvc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // heading error
  assign hn     = wrap_ang(18'(hd_q));
  assign gyw    = wrap_ang(18'(gyaw_q));
  assign od     = wrap_ang(gyw - hn);
  assign od_mag = od[17] ? $unsigned(-od) : $unsigned(od);

  assign cor_start = (state_q == ST_MODES);

  cfvc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (hn[15:0]),
    .busy_o  (cor_busy),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // tangent and radial error
  assign dir_new = (dir_q != DIR_NONE) ? dir_q : (py_q[31] ? DIR_CCW : DIR_CW);
  assign uxs     = ux_q[31:14];
  assign uys     = uy_q[31:14];
  assign ediff   = $signed({2'b00, rad_q}) - $signed({2'b00, r_q});

  assign w_mag = $signed({1'b0, (rot_q == MODE_FULL) ? rot_spd_q : wslow_q});

  // sequencer
  always_comb begin
    state_d     = state_q;
    nsel_d      = nsel_q;
    dsel_d      = dsel_q;
    dir_d       = dir_q;
    lin_d       = lin_q;
    rot_d       = rot_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_i == CMD_ODOM) begin
            state_d = ST_NA;
            nsel_d  = NS_R;
          end else begin
            dir_d = DIR_NONE;
          end
        end
      end
      ST_NA: state_d = ST_NB;
      ST_NB: state_d = ST_NC;
      ST_NC: state_d = ST_NW;
      ST_NW: begin
        if (!sq_busy) begin
          unique case (nsel_q)
            NS_R: begin
              state_d = ST_NA;
              nsel_d  = NS_RAD;
            end
            NS_RAD: begin
              if (r_q == '0) begin
                state_d = ST_LATCH;
              end else begin
                state_d = ST_DGO;
                dsel_d  = DS_UX;
              end
            end
            NS_D: begin
              if (sq_root == '0) begin
                state_d = ST_NA;
                nsel_d  = NS_DE;
              end else begin
                state_d = ST_DGO;
                dsel_d  = DS_NX;
              end
            end
            default: state_d = ST_MODES;
          endcase
        end
      end
      ST_DGO: state_d = ST_DW;
      ST_DW: begin
        if (!div_busy) begin
          unique case (dsel_q)
            DS_UX: begin state_d = ST_DGO; dsel_d = DS_UY; end
            DS_UY: state_d = ST_LATCH;
            DS_NX: begin state_d = ST_DGO; dsel_d = DS_NY; end
            DS_NY: begin state_d = ST_NA;  nsel_d = NS_DE; end
            DS_GS: begin state_d = ST_DGO; dsel_d = DS_WS; end
            default: state_d = ST_CW;
          endcase
        end
      end
      ST_LATCH: begin
        dir_d   = dir_new;
        state_d = ST_M0;
      end
      ST_M0: state_d = ST_M1;
      ST_M1: state_d = ST_M2;
      ST_M2: begin
        state_d = ST_NA;
        nsel_d  = NS_D;
      end
      ST_MODES: begin
        lin_d   = hyst(lin_q, de_q, DIST_LO, DIST_HI);
        rot_d   = hyst(rot_q, {14'd0, od_mag}, ANG_LO, ANG_HI);
        state_d = ST_DGO;
        dsel_d  = DS_GS;
      end
      ST_CW: if (!cor_busy) state_d = ST_P0;
      ST_P0: state_d = ST_P1;
      ST_P1: state_d = ST_P2;
      ST_P2: state_d = ST_P3;
      ST_P3: state_d = ST_P4;
      ST_P4: state_d = ST_P5;
      ST_P5: state_d = ST_P6;
      ST_P6: state_d = ST_P7;
      ST_P7: state_d = ST_P8;
      ST_P8: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nsel_q      <= NS_R;
      dsel_q      <= DS_UX;
      dir_q       <= DIR_NONE;
      lin_q       <= MODE_STOP;
      rot_q       <= MODE_STOP;
      out_valid_q <= 1'b0;
      lin_spd_q   <= LIN_SPEED_RST;
      rot_spd_q   <= ROT_SPEED_RST;
      slow_q      <= SLOWDOWN_RST;
      gx_q        <= '0;
      gy_q        <= '0;
      gyaw_q      <= '0;
    end else begin
      state_q     <= state_d;
      nsel_q      <= nsel_d;
      dsel_q      <= dsel_d;
      dir_q       <= dir_d;
      lin_q       <= lin_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LIN_SPEED: lin_spd_q <= cfg_data_i;
          CFG_ROT_SPEED: rot_spd_q <= cfg_data_i;
          CFG_SLOWDOWN:  slow_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire && cmd_i == CMD_GOAL) begin
        gx_q   <= pos_x_i;
        gy_q   <= pos_y_i;
        gyaw_q <= heading_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && cmd_i == CMD_ODOM) begin
          px_q <= pos_x_i;
          py_q <= pos_y_i;
          hd_q <= heading_i;
        end
      end
      ST_NB: acc_q <= prod_q;
      ST_NW: begin
        if (!sq_busy) begin
          unique case (nsel_q)
            NS_R: r_q <= sq_root;
            NS_RAD: begin
              rad_q <= sq_root;
              // robot at the origin points along x
              if (r_q == '0) begin
                ux_q <= ONE_Q30;
                uy_q <= '0;
              end
            end
            NS_D: begin
              d_q <= sq_root;
              if (sq_root == '0) begin
                nx_q <= '0;
                ny_q <= '0;
              end
            end
            default: de_q <= sq_root;
          endcase
        end
      end
      ST_DW: begin
        if (!div_busy) begin
          unique case (dsel_q)
            DS_UX:   ux_q    <= div_res;
            DS_UY:   uy_q    <= div_res;
            DS_NX:   nx_q    <= div_res;
            DS_NY:   ny_q    <= div_res;
            DS_GS:   gslow_q <= div_res[CfgW-1:0];
            default: wslow_q <= div_res[CfgW-1:0];
          endcase
        end
      end
      ST_LATCH: begin
        if (dir_new == DIR_CW) begin
          tx_q <= uys;
          ty_q <= -uxs;
        end else begin
          tx_q <= -uys;
          ty_q <= uxs;
        end
        e_q <= clamp31(36'(ediff));
      end
      ST_M1: vlx_q <= clamp31(36'(tx_q) + 36'(prod_q >>> 29));
      ST_M2: vly_q <= clamp31(36'(ty_q) + 36'(prod_q >>> 29));
      ST_MODES: od_q <= od;
      ST_P1: t1_q <= 32'(prod_q >>> 30);
      ST_P2: t2_q <= 32'(prod_q >>> 30);
      ST_P3: t3_q <= 32'(prod_q >>> 30);
      ST_P4: t4_q <= 32'(prod_q >>> 30);
      ST_P5: acc_q <= prod_q;
      ST_P6: vx_q <= sat16(36'((acc_q + prod_q) >>> 30));
      ST_P7: acc_q <= prod_q;
      ST_P8: vy_q <= sat16(36'((acc_q - prod_q) >>> 30));
      ST_OUT: begin
        if (out_load) begin
          vel_x_q    <= (lin_q == MODE_STOP) ? '0 : vx_q;
          vel_y_q    <= (lin_q == MODE_STOP) ? '0 : vy_q;
          if (rot_q == MODE_STOP) ang_vel_q <= '0;
          else if (od_q <= 0) ang_vel_q <= -w_mag;
          else ang_vel_q <= w_mag;
          lin_mode_q <= lin_q;
          rot_mode_q <= rot_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;
  assign ang_vel_o   = ang_vel_q;
  assign lin_mode_o  = lin_mode_q;
  assign rot_mode_o  = rot_mode_q;

`ifndef SYNTH
  a_odom_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_ODOM |=> !in_ready_o)
    else $error("input still ready after an odometry beat");

  a_dir_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_M0 |-> dir_q != DIR_NONE)
    else $error("tangent direction undecided after latch step");

  a_stop_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lin_mode_o == MODE_STOP |-> vel_x_o == '0 && vel_y_o == '0)
    else $error("nonzero velocity in linear stop mode");
`endif

endmodule
